/* design/bec_pkg.sv */
// bec_pkg: shared types and constants of the backspace edit compare block
// no dependencies; used by every other design file but bec_ram through scoped names

package bec_pkg;

  localparam int unsigned CharWidth = 8;
  localparam logic [CharWidth-1:0] BsReset = 8'd35;

  typedef enum logic [1:0] {
    OP_FIRST   = 2'd0,
    OP_SECOND  = 2'd1,
    OP_COMPARE = 2'd2
  } op_e;

  // edit command from the top level to one stack
  typedef struct packed {
    logic                 edit;
    logic                 is_bs;
    logic                 clear;
    logic [CharWidth-1:0] ch;
  } stk_cmd_t;

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_WALK = 3'b010,
    W_DONE = 3'b100
  } walk_state_e;

endpackage

/* design/bec_if.sv */
// bec_in_if and bec_out_if: valid/ready channels of the edit compare block
// depends on bec_pkg for the character width

interface bec_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [bec_pkg::CharWidth-1:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface bec_out_if;
  logic valid;
  logic ready;
  logic strings_equal;
  logic overflowed;

  modport source (output valid, output strings_equal, output overflowed, input ready);
  modport sink (input valid, input strings_equal, input overflowed, output ready);
endinterface

/* design/bec_ram.sv */
// bec_ram: generic single write port, single read port ram, registered read
// no dependencies

module bec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/bec_stack.sv */
// bec_stack: one character stack, fill level register plus a bec_ram
// depends on bec_pkg and bec_ram

module bec_stack #(
  parameter int unsigned StackDepth = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bec_pkg::stk_cmd_t                   cmd_i,
  output logic [$clog2(StackDepth+1)-1:0]     count_o,
  output logic                                drop_o,
  input  logic                                re_i,
  input  logic [$clog2(StackDepth)-1:0]       raddr_i,
  output logic [bec_pkg::CharWidth-1:0]       rdata_o
);

  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam int unsigned AW = $clog2(StackDepth);

  logic [CW-1:0] count_q, count_d;
  logic          full;
  logic          push;

  assign full   = (count_q == CW'(StackDepth));
  assign push   = cmd_i.edit && !cmd_i.is_bs && !full;
  assign drop_o = cmd_i.edit && !cmd_i.is_bs && full;
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.edit) begin
      if (cmd_i.is_bs) begin
        if (count_q != '0) begin
          count_d = count_q - CW'(1);
        end
      end else if (!full) begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  bec_ram #(
    .Width (bec_pkg::CharWidth),
    .Depth (StackDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (cmd_i.ch),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata_o)
  );

endmodule

/* design/bec_walk.sv */
// bec_walk: compare sequencer, reads both stacks entry by entry, holds the result word
// depends on bec_pkg

module bec_walk #(
  parameter int unsigned StackDepth = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(StackDepth+1)-1:0]   count_a_i,
  input  logic [$clog2(StackDepth+1)-1:0]   count_b_i,
  input  logic                              ovf_i,
  output logic                              idle_o,
  output logic                              re_o,
  output logic [$clog2(StackDepth)-1:0]     raddr_o,
  input  logic [bec_pkg::CharWidth-1:0]     rdata_a_i,
  input  logic [bec_pkg::CharWidth-1:0]     rdata_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_equal_o,
  output logic                              out_ovf_o
);

  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam int unsigned AW = $clog2(StackDepth);

  bec_pkg::walk_state_e state_q, state_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic          mism_q, mism_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  logic          out_equal_q, out_equal_d;
  logic          out_ovf_q, out_ovf_d;
  logic          load;

  assign idle_o      = (state_q == bec_pkg::W_IDLE);
  assign re_o        = (state_q == bec_pkg::W_WALK) && (iss_q != len_q);
  assign raddr_o     = iss_q[AW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_equal_o = out_equal_q;
  assign out_ovf_o   = out_ovf_q;

  assign load = (state_q == bec_pkg::W_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    iss_d   = iss_q;
    pend_d  = 1'b0;
    mism_d  = mism_q;
    ovf_d   = ovf_q;
    case (state_q)
      bec_pkg::W_IDLE: begin
        if (start_i) begin
          // unequal lengths skip the walk
          len_d   = (count_a_i == count_b_i) ? count_a_i : '0;
          mism_d  = (count_a_i != count_b_i);
          ovf_d   = ovf_i;
          iss_d   = '0;
          state_d = bec_pkg::W_WALK;
        end
      end
      bec_pkg::W_WALK: begin
        pend_d = re_o;
        if (re_o) begin
          iss_d = iss_q + CW'(1);
        end
        if (pend_q && (rdata_a_i != rdata_b_i)) begin
          mism_d = 1'b1;
        end
        if (!re_o && !pend_q) begin
          state_d = bec_pkg::W_DONE;
        end
      end
      bec_pkg::W_DONE: begin
        if (load) begin
          state_d = bec_pkg::W_IDLE;
        end
      end
      default: begin
        state_d = bec_pkg::W_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_equal_d = out_equal_q;
    out_ovf_d   = out_ovf_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_equal_d = !mism_q;
      out_ovf_d   = ovf_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bec_pkg::W_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    iss_q       <= iss_d;
    mism_q      <= mism_d;
    ovf_q       <= ovf_d;
    out_equal_q <= out_equal_d;
    out_ovf_q   <= out_ovf_d;
  end

endmodule

/* design/backspace_edit_compare.sv */
// backspace_edit_compare: top level, two character stacks and the compare sequencer
// depends on bec_pkg, bec_if, bec_stack and bec_walk
//
//   port     dir  word                      handshake
//   in_i     in   opcode, char_code         valid/ready
//   out_o    out  strings_equal, overflowed valid/ready
//   cfg      in   cfg_wdata_i (backspace)   cfg_we_i, no wait
//
// character words (push or pop) are taken back to back while no compare runs
// a compare walks the filled entries of both stacks when both fill levels match
// and skips the walk otherwise; the walk reads one entry of each stack ram per
// cycle, compares each pair as the registered ram read returns it, and in_i.ready is low meanwhile
// a result waiting on out_o stalls only the end of the next compare
// reset clears fill levels and the overflow flag; stack rams need no clearing

module backspace_edit_compare #(
  parameter int unsigned StackDepth = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bec_pkg::CharWidth-1:0] cfg_wdata_i,
  bec_in_if.sink                        in_i,
  bec_out_if.source                     out_o
);

  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam int unsigned AW = $clog2(StackDepth);

  logic [bec_pkg::CharWidth-1:0] bs_q;
  logic                          ovf_q;
  logic                          accept;
  logic                          start;
  logic                          is_bs;
  bec_pkg::stk_cmd_t             cmd_a, cmd_b;
  logic [CW-1:0]                 count_a, count_b;
  logic                          drop_a, drop_b;
  logic                          walk_idle;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [bec_pkg::CharWidth-1:0] rdata_a, rdata_b;

  assign in_i.ready = walk_idle;
  assign accept     = in_i.valid && in_i.ready;
  assign is_bs      = (in_i.char_code == bs_q);

  always_comb begin
    start       = 1'b0;
    cmd_a.edit  = 1'b0;
    cmd_b.edit  = 1'b0;
    cmd_a.is_bs = is_bs;
    cmd_b.is_bs = is_bs;
    cmd_a.ch    = in_i.char_code;
    cmd_b.ch    = in_i.char_code;
    case (in_i.opcode)
      bec_pkg::OP_FIRST:   cmd_a.edit = accept;
      bec_pkg::OP_SECOND:  cmd_b.edit = accept;
      bec_pkg::OP_COMPARE: start      = accept;
      default: ;
    endcase
    cmd_a.clear = start;
    cmd_b.clear = start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= bec_pkg::BsReset;
      ovf_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bs_q <= cfg_wdata_i;
      end
      if (start) begin
        ovf_q <= 1'b0;
      end else if (drop_a || drop_b) begin
        ovf_q <= 1'b1;
      end
    end
  end

  bec_stack #(.StackDepth(StackDepth)) u_stack_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_a),
    .count_o (count_a),
    .drop_o  (drop_a),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata_a)
  );

  bec_stack #(.StackDepth(StackDepth)) u_stack_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_b),
    .count_o (count_b),
    .drop_o  (drop_b),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata_b)
  );

  bec_walk #(.StackDepth(StackDepth)) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .count_a_i   (count_a),
    .count_b_i   (count_b),
    .ovf_i       (ovf_q),
    .idle_o      (walk_idle),
    .re_o        (rd_en),
    .raddr_o     (rd_addr),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_equal_o (out_o.strings_equal),
    .out_ovf_o   (out_o.overflowed)
  );

endmodule

/* design/bec_chk.sv */
// bec_chk: port-level assertions for backspace_edit_compare, bound to the top level
// depends on bec_pkg for opcode names

module bec_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_opcode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_equal_i,
  input logic       out_ovf_i
);

  logic in_acc;
  logic is_cmp;

  assign in_acc = in_valid_i && in_ready_i;
  assign is_cmp = (in_opcode_i == bec_pkg::OP_COMPARE);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_equal_i) && $stable(out_ovf_i))
    else $error("result word changed while stalled");

  // a compare blocks the input side while it walks
  a_cmp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_cmp |=> !in_ready_i)
    else $error("input ready right after a compare");

  // character words never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_cmp && !out_valid_i |=> !out_valid_i)
    else $error("result without a compare");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind backspace_edit_compare bec_chk u_bec_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_equal_i (out_o.strings_equal),
  .out_ovf_i   (out_o.overflowed)
);

/* tb/backspace_edit_compare_tb.sv */
// backspace_edit_compare_tb: self-checking bench for the backspace edit compare block
// keeps its own model of both character stacks and checks every compare verdict
// depends on bec_pkg, bec_if and the backspace_edit_compare top level

module backspace_edit_compare_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = 256;
  localparam logic [1:0]  OpUnused   = 2'd3;
  // longest compare walk plus some slack
  localparam int unsigned Latency    = StackDepth + 8;
  localparam int unsigned CycleLimit = 600_000;

  typedef logic [bec_pkg::CharWidth-1:0] char_t;

  typedef struct packed {
    logic [1:0] opcode;
    char_t      ch;
  } word_t;

  typedef struct packed {
    logic strings_equal;
    logic overflowed;
  } verdict_t;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  char_t cfg_wdata_i;

  bec_in_if  in_if ();
  bec_out_if out_if ();

  backspace_edit_compare #(
    .StackDepth(StackDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stack model
  // ---------------------------------------------------------------------------
  char_t       held [2][StackDepth];
  int unsigned fill [2] = '{0, 0};
  logic        dropped_char = 1'b0;
  char_t       erase_code = bec_pkg::BsReset;
  verdict_t    verdict_q [$];

  task automatic edit_string(input int side, input char_t ch);
    if (ch == erase_code) begin
      if (fill[side] > 0) fill[side]--;
    end else if (fill[side] < StackDepth) begin
      held[side][fill[side]] = ch;
      fill[side]++;
    end else begin
      dropped_char = 1'b1;
    end
  endtask

  task automatic track_word(input word_t w);
    verdict_t v;
    case (w.opcode)
      bec_pkg::OP_FIRST:  edit_string(0, w.ch);
      bec_pkg::OP_SECOND: edit_string(1, w.ch);
      bec_pkg::OP_COMPARE: begin
        v.strings_equal = (fill[0] == fill[1]);
        for (int i = 0; i < fill[0] && v.strings_equal; i++)
          if (held[0][i] != held[1][i]) v.strings_equal = 1'b0;
        v.overflowed = dropped_char;
        verdict_q = {verdict_q, v};
        fill[0] = 0;
        fill[1] = 0;
        dropped_char = 1'b0;
      end
      default: ;  // unused opcode leaves everything alone
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // word sender, receiver stalls and result checker
  // ---------------------------------------------------------------------------
  word_t       typed_q [$];
  bit          in_fire;
  int unsigned gap_left, burst_left, stall_left, mode_left, ready_mode;
  int unsigned cycle_cnt, mismatches, words_queued, verdicts_seen, equal_seen, overflow_seen;

  always @(negedge clk_i) begin : drive
    logic  nv;
    logic  nr;
    word_t nw;
    nv = in_if.valid && !in_fire;  // word still waiting for acceptance
    nw = {in_if.opcode, in_if.char_code};
    if (!nv && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (typed_q.size() > 0) begin
        nw = typed_q.pop_front();
        nv = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    // receiver: always ready, coin flips, or long stalls, switching now and then
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: nr = 1'b1;
      1: nr = 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          nr = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 12);
          nr = 1'b0;
        end else begin
          nr = 1'b1;
        end
      end
    endcase
    in_if.valid     <= nv;
    in_if.opcode    <= nw.opcode;
    in_if.char_code <= nw.ch;
    out_if.ready    <= nr;
  end

  always @(posedge clk_i) begin : watch
    verdict_t want;
    cycle_cnt++;
    in_fire = rst_ni && in_if.valid && in_if.ready;
    if (in_fire) track_word({in_if.opcode, in_if.char_code});
    if (rst_ni && out_if.valid && out_if.ready) begin
      verdicts_seen++;
      if (out_if.strings_equal) equal_seen++;
      if (out_if.overflowed) overflow_seen++;
      if (verdict_q.size() == 0) begin
        $error("verdict word with no compare pending");
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.strings_equal !== want.strings_equal) begin
          $error("strings_equal: expected %0b, got %0b", want.strings_equal, out_if.strings_equal);
          mismatches++;
        end
        if (out_if.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, out_if.overflowed);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------
  char_t phase_bs;
  char_t txt_a [$];
  char_t txt_b [$];
  word_t lane_a [$];
  word_t lane_b [$];

  task automatic send(input logic [1:0] op, input char_t ch);
    word_t w;
    w.opcode = op;
    w.ch     = ch;
    typed_q  = {typed_q, w};
    if (op != OpUnused) words_queued++;
  endtask

  // any byte except the current erase code
  function automatic char_t pick_char();
    char_t c;
    do c = char_t'($urandom_range(0, 255)); while (c == phase_bs);
    return c;
  endfunction

  task automatic lane_push(input bit side, input char_t ch);
    word_t w;
    w.opcode = side ? bec_pkg::OP_SECOND : bec_pkg::OP_FIRST;
    w.ch     = ch;
    if (side) lane_b = {lane_b, w};
    else lane_a = {lane_a, w};
  endtask

  // types the target text with stray erasures and typos that get erased again
  task automatic type_lane(input bit side);
    int unsigned n;
    int unsigned k;
    n = side ? txt_b.size() : txt_a.size();
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) lane_push(side, phase_bs);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 3);
        repeat (k) lane_push(side, pick_char());
        repeat (k) lane_push(side, phase_bs);
      end
      lane_push(side, side ? txt_b[i] : txt_a[i]);
    end
  endtask

  task automatic gen_pair();
    int unsigned len;
    int unsigned idx;
    char_t       c;
    word_t       w;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    txt_a.delete();
    repeat (len) txt_a = {txt_a, pick_char()};
    txt_b = txt_a;
    if ($urandom_range(0, 3) == 0) begin
      if (len > 0 && $urandom_range(0, 1)) begin
        idx = $urandom_range(0, len - 1);
        do c = pick_char(); while (c == txt_b[idx]);
        txt_b[idx] = c;
      end else if (len > 0 && $urandom_range(0, 1)) begin
        txt_b.delete(txt_b.size() - 1);
      end else begin
        txt_b = {txt_b, pick_char()};
      end
    end
    lane_a.delete();
    lane_b.delete();
    type_lane(0);
    type_lane(1);
    while (lane_a.size() + lane_b.size() > 0) begin
      if ($urandom_range(0, 15) == 0) send(OpUnused, char_t'($urandom_range(0, 255)));
      if (lane_b.size() == 0 || (lane_a.size() > 0 && $urandom_range(0, 1))) w = lane_a.pop_front();
      else w = lane_b.pop_front();
      send(w.opcode, w.ch);
    end
    send(bec_pkg::OP_COMPARE, char_t'($urandom_range(0, 255)));
  endtask

  task automatic gen_noise();
    logic [1:0] op;
    repeat ($urandom_range(1, 12)) begin
      op = 2'($urandom_range(0, 3));
      send(op, ($urandom_range(0, 3) == 0) ? phase_bs : char_t'($urandom_range(0, 255)));
    end
    send(bec_pkg::OP_COMPARE, char_t'($urandom_range(0, 255)));
  endtask

  // runs one stack past full, then edits it so the flag has to stay set
  task automatic gen_fill();
    bit         side;
    logic [1:0] op;
    logic [1:0] other;
    side  = 1'($urandom_range(0, 1));
    op    = side ? bec_pkg::OP_SECOND : bec_pkg::OP_FIRST;
    other = side ? bec_pkg::OP_FIRST : bec_pkg::OP_SECOND;
    repeat (StackDepth + $urandom_range(1, 3)) send(op, pick_char());
    repeat (2) send(op, phase_bs);
    send(op, pick_char());
    repeat ($urandom_range(0, 3)) send(other, pick_char());
    send(bec_pkg::OP_COMPARE, char_t'($urandom_range(0, 255)));
  endtask

  task automatic gen_phase(input char_t code, input int unsigned budget, input bit with_fill);
    int unsigned start;
    phase_bs = code;
    start    = words_queued;
    if (with_fill) gen_fill();
    while (words_queued - start < budget) begin
      if ($urandom_range(0, 4) == 0) gen_noise();
      else gen_pair();
    end
  endtask

  task automatic gen_directed();
    phase_bs = bec_pkg::BsReset;
    send(bec_pkg::OP_COMPARE, 8'hFF);             // both strings empty
    send(bec_pkg::OP_FIRST, bec_pkg::BsReset);    // erase on empty stacks
    send(bec_pkg::OP_SECOND, bec_pkg::BsReset);
    send(bec_pkg::OP_FIRST, 8'h00);
    send(bec_pkg::OP_FIRST, 8'hFF);
    send(bec_pkg::OP_SECOND, 8'h00);
    send(bec_pkg::OP_SECOND, 8'h7F);
    send(bec_pkg::OP_SECOND, bec_pkg::BsReset);
    send(bec_pkg::OP_SECOND, 8'hFF);
    send(OpUnused, 8'hAA);
    send(OpUnused, bec_pkg::BsReset);
    send(bec_pkg::OP_COMPARE, 8'h00);
    send(bec_pkg::OP_FIRST, 8'h61);
    send(bec_pkg::OP_SECOND, 8'h62);
    send(bec_pkg::OP_COMPARE, 8'h55);
    send(bec_pkg::OP_FIRST, 8'h61);
    send(bec_pkg::OP_FIRST, 8'h62);
    send(bec_pkg::OP_SECOND, 8'h61);
    send(bec_pkg::OP_COMPARE, 8'hAA);
    send(bec_pkg::OP_COMPARE, 8'h00);
  endtask

  // waits until every word is taken and every verdict is back, then lets the block go quiet
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (typed_q.size() != 0 || in_if.valid || verdict_q.size() != 0);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic set_erase_code(input char_t code);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    erase_code = code;
  endtask

  initial begin : stimulus
    char_t mid_code;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = bec_pkg::OP_FIRST;
    in_if.char_code  = '0;
    out_if.ready     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    gen_directed();
    settle();
    set_erase_code(8'h00);
    gen_phase(8'h00, 100, 1'b0);
    settle();
    set_erase_code(8'hFF);
    gen_phase(8'hFF, 100, 1'b0);
    settle();
    mid_code = char_t'($urandom_range(1, 254));
    set_erase_code(mid_code);
    gen_phase(mid_code, 340, 1'b1);
    settle();
    set_erase_code(bec_pkg::BsReset);
    gen_phase(bec_pkg::BsReset, 100, 1'b0);
    settle();

    $display("%0d edit and compare words sent, %0d verdicts checked (%0d equal, %0d overflowed)",
             words_queued, verdicts_seen, equal_seen, overflow_seen);
    $display("erase codes covered: reset value, 0x00, 0xff and 0x%02h", mid_code);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bec_pkg.sv
design/bec_if.sv
design/bec_ram.sv
design/bec_stack.sv
design/bec_walk.sv
design/backspace_edit_compare.sv
design/bec_chk.sv
tb/backspace_edit_compare_tb.sv
